/* rtl/mcvlf_pkg.sv */
// Shared types and constants for the multi-channel variable-length FIFO.
package mcvlf_pkg;

   localparam int DATA_W  = 64;
   localparam int LEN_W   = 4;
   localparam int COUNT_W = 5;
   localparam int CSR_W   = 5;
   localparam int BYTE_W  = 8;
   localparam int NUM_BYTE_LANES = DATA_W / BYTE_W;

   typedef enum logic [1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_DEQUEUE  = 2'd1,
      OP_STATUS   = 2'd2,
      OP_RESERVED = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_LEN = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef enum logic {
      CSR_DEPTH_IN_USE    = 1'b0,
      CSR_MAX_ENTRY_BYTES = 1'b1
   } csr_index_type;

endpackage

/* rtl/multi_channel_variable_length_fifo.sv */
// Two-stage FIFO: request register, then result register fed by the entry memory read.
// Accepted requests pass the request register, then the result register that drives rsp_.
// Throughput: one request per cycle while results are taken; while a result waits, the
// request stage takes a transfer only if empty, and stalls when both stages are held.
// Reset: synchronous, active high; clears pointers, counts, valid flags and restores
// depth_in_use to 16 and max_entry_bytes to 8. Entry storage is not cleared.
module multi_channel_variable_length_fifo
   import mcvlf_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int QUEUE_DEPTH  = 16,
   parameter int ENTRY_BYTES  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [2:0]         req_channel,
   input  logic [LEN_W-1:0]   req_write_length,
   input  logic [DATA_W-1:0]  req_write_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [DATA_W-1:0]  rsp_read_data,
   output logic [LEN_W-1:0]   rsp_read_length,
   output logic [COUNT_W-1:0] rsp_fill_count,
   output logic               rsp_is_empty,
   output logic               rsp_is_full,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_write_data
);

   localparam int CHAN_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int SLOTS  = NUM_CHANNELS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int WORD_W = LEN_W + DATA_W;

   // Configuration registers.
   logic [COUNT_W-1:0] depth_in_use_ff;
   logic [LEN_W-1:0]   max_entry_bytes_ff;

   // Per-channel queue state.
   logic [PTR_W-1:0]   head_ff  [NUM_CHANNELS];
   logic [PTR_W-1:0]   tail_ff  [NUM_CHANNELS];
   logic [COUNT_W-1:0] count_ff [NUM_CHANNELS];
   logic [PTR_W-1:0]   head_in  [NUM_CHANNELS];
   logic [PTR_W-1:0]   tail_in  [NUM_CHANNELS];
   logic [COUNT_W-1:0] count_in [NUM_CHANNELS];

   // Entry storage: stored length above the data bytes.
   logic [WORD_W-1:0]  store_mem [SLOTS];
   logic [WORD_W-1:0]  rd_word_ff;

   // Request stage.
   logic               s0_valid_ff;
   logic [1:0]         s0_opcode_ff;
   logic [2:0]         s0_channel_ff;
   logic [LEN_W-1:0]   s0_length_ff;
   logic [DATA_W-1:0]  s0_data_ff;

   // Result stage.
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [COUNT_W-1:0] rsp_fill_count_ff;
   logic               rsp_empty_ff;
   logic               rsp_full_ff;
   logic               rsp_deq_ok_ff;

   status_type         status_in;
   logic [COUNT_W-1:0] fill_count_in;
   logic               empty_in;
   logic               full_in;

   logic               s0_move;
   logic               enq_ok;
   logic               deq_ok;
   logic [CHAN_W-1:0]  chan;
   logic [COUNT_W-1:0] eff_depth;
   logic [LEN_W-1:0]   eff_max_len;
   logic [PTR_W-1:0]   head_next;
   logic [PTR_W-1:0]   tail_next;
   logic [PTR_W-1:0]   ptr_sel;
   logic [ADDR_W-1:0]  slot_addr;
   logic [DATA_W-1:0]  masked_data;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                input logic [COUNT_W-1:0] depth);
      logic [PTR_W:0] n;
      n = {1'b0, ptr} + (PTR_W+1)'(1);
      if ((32'(n) >= 32'(depth)) || (32'(n) >= QUEUE_DEPTH)) begin
         return '0;
      end
      return n[PTR_W-1:0];
   endfunction

   assign s0_move   = s0_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s0_valid_ff || s0_move;

   // Effective limits after clamping the register values.
   always_comb begin
      if (depth_in_use_ff == '0) begin
         eff_depth = COUNT_W'(1);
      end else if (32'(depth_in_use_ff) > QUEUE_DEPTH) begin
         eff_depth = COUNT_W'(QUEUE_DEPTH);
      end else begin
         eff_depth = depth_in_use_ff;
      end
      if (32'(max_entry_bytes_ff) > ENTRY_BYTES) begin
         eff_max_len = LEN_W'(ENTRY_BYTES);
      end else begin
         eff_max_len = max_entry_bytes_ff;
      end
   end

   // Channel numbers beyond the channel count fold back by repeated subtraction.
   always_comb begin
      logic [2:0] v;
      v = s0_channel_ff;
      for (int i = 0; i < 8; i++) begin
         if (32'(v) >= NUM_CHANNELS) begin
            v = v - 3'(NUM_CHANNELS);
         end
      end
      chan = CHAN_W'(v);
   end

   // Only the low write_length bytes are kept.
   always_comb begin
      for (int b = 0; b < NUM_BYTE_LANES; b++) begin
         if (LEN_W'(b) < s0_length_ff) begin
            masked_data[b*BYTE_W +: BYTE_W] = s0_data_ff[b*BYTE_W +: BYTE_W];
         end else begin
            masked_data[b*BYTE_W +: BYTE_W] = '0;
         end
      end
   end

   always_comb begin
      status_in = ST_OK;
      enq_ok    = 1'b0;
      deq_ok    = 1'b0;
      case (opcode_type'(s0_opcode_ff))
         OP_ENQUEUE: begin
            if ((s0_length_ff == '0) || (s0_length_ff > eff_max_len)) begin
               status_in = ST_BAD_LEN;
            end else if (count_ff[chan] >= eff_depth) begin
               status_in = ST_FULL;
            end else begin
               enq_ok = 1'b1;
            end
         end
         OP_DEQUEUE: begin
            if (count_ff[chan] == '0) begin
               status_in = ST_EMPTY;
            end else begin
               deq_ok = 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign head_next = advance(head_ff[chan], eff_depth);
   assign tail_next = advance(tail_ff[chan], eff_depth);
   assign ptr_sel   = (opcode_type'(s0_opcode_ff) == OP_ENQUEUE) ? tail_ff[chan] : head_ff[chan];
   assign slot_addr = ADDR_W'(chan) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr_sel);

   always_comb begin
      fill_count_in = count_ff[chan];
      if (enq_ok) begin
         fill_count_in = count_ff[chan] + COUNT_W'(1);
      end else if (deq_ok) begin
         fill_count_in = count_ff[chan] - COUNT_W'(1);
      end
      empty_in = (fill_count_in == '0);
      full_in  = (fill_count_in >= eff_depth);
   end

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         head_in[c]  = head_ff[c];
         tail_in[c]  = tail_ff[c];
         count_in[c] = count_ff[c];
      end
      if (s0_move) begin
         count_in[chan] = fill_count_in;
         if (enq_ok) begin
            tail_in[chan] = tail_next;
         end
         if (deq_ok) begin
            head_in[chan] = head_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_in_use_ff    <= COUNT_W'(16);
         max_entry_bytes_ff <= LEN_W'(8);
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DEPTH_IN_USE:    depth_in_use_ff    <= csr_write_data;
            CSR_MAX_ENTRY_BYTES: max_entry_bytes_ff <= csr_write_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            head_ff[c]  <= head_in[c];
            tail_ff[c]  <= tail_in[c];
            count_ff[c] <= count_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_move && enq_ok) begin
         store_mem[slot_addr] <= {s0_length_ff, masked_data};
      end
      if (s0_move && deq_ok) begin
         rd_word_ff <= store_mem[slot_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s0_opcode_ff  <= req_opcode;
         s0_channel_ff <= req_channel;
         s0_length_ff  <= req_write_length;
         s0_data_ff    <= req_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s0_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_move) begin
         rsp_status_ff     <= status_in;
         rsp_fill_count_ff <= fill_count_in;
         rsp_empty_ff      <= empty_in;
         rsp_full_ff       <= full_in;
         rsp_deq_ok_ff     <= deq_ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_deq_ok_ff ? rd_word_ff[DATA_W-1:0] : '0;
   assign rsp_read_length = rsp_deq_ok_ff ? rd_word_ff[WORD_W-1:DATA_W] : '0;
   assign rsp_fill_count  = rsp_fill_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

endmodule

/* rtl/mcvlf_checker.sv */
// Port-level checks for the multi-channel variable-length FIFO, bound to the top level.
module mcvlf_checker
   import mcvlf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [DATA_W-1:0]  rsp_read_data,
   input logic [LEN_W-1:0]   rsp_read_length,
   input logic [COUNT_W-1:0] rsp_fill_count,
   input logic               rsp_is_empty,
   input logic               rsp_is_full
);

   // A failed transfer carries no entry; only failed transfers are checked here.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_read_data == '0) && (rsp_read_length == '0))
      else $error("read data present on a failed request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_fill_count == '0)))
      else $error("empty flag disagrees with fill count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_is_empty && !rsp_is_full)
      else $error("empty status on a channel that is not empty");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_is_full && !rsp_is_empty)
      else $error("full status on a channel that is not full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fill_count) && $stable(rsp_status))
      else $error("result changed while stalled");

endmodule

bind multi_channel_variable_length_fifo mcvlf_checker u_mcvlf_checker (.*);
